// ===== rtl/tpk_pkg.sv =====
// shared types, codes and helpers for the priority round robin task picker
package tpk_pkg;

    localparam int NUM_SLOTS     = 16;
    localparam int PRIORITY_BITS = 8;
    localparam int IW            = $clog2(NUM_SLOTS);
    localparam int CW            = $clog2(NUM_SLOTS + 2);
    localparam int SCAN_LAST     = NUM_SLOTS + 1;
    localparam int CNT_W         = 17;
    localparam int BUDGET_W      = 16;
    localparam int READY_W       = 16;
    localparam int SLOT_W        = 4;
    localparam int PRIO_IN_W     = 8;

    typedef logic [IW-1:0]            idx_t;
    typedef logic [PRIORITY_BITS-1:0] prio_t;
    typedef logic [CNT_W-1:0]         cnt_t;

    localparam logic [2:0] MODE_SCHED = 3'd0;
    localparam logic [2:0] MODE_WAKE  = 3'd1;
    localparam logic [2:0] MODE_REG   = 3'd2;
    localparam logic [2:0] MODE_UPD   = 3'd3;
    localparam logic [2:0] MODE_DEREG = 3'd4;

    localparam logic [1:0] OC_SELECT = 2'd0;
    localparam logic [1:0] OC_WAIT   = 2'd1;
    localparam logic [1:0] OC_NONE   = 2'd2;
    localparam logic [1:0] OC_TABLE  = 2'd3;

    typedef struct packed {
        logic [2:0]           mode;
        logic [SLOT_W-1:0]    slot;
        logic [PRIO_IN_W-1:0] task_priority;
        logic                 can_switch;
        logic                 may_block;
        logic                 not_stable;
        logic [READY_W-1:0]   ready_mask;
    } in_t;

    typedef struct packed {
        logic [1:0]        outcome;
        logic [SLOT_W-1:0] chosen_slot;
        logic              by_status_change;
        logic              wait_on_current;
    } out_t;

    // one table entry as kept in the slot memory
    typedef struct packed {
        prio_t prio;
        logic  sw;
        logic  blk;
        logic  uns;
        cnt_t  cnt;
    } ent_t;

    typedef struct packed {
        logic  start;
        logic  ev;
        logic  kind_next;
        logic  present;
        idx_t  idx;
        idx_t  cur;
        prio_t curprio;
        logic  slot_valid;
        logic  rdy;
    } scan_ctl_t;

    typedef struct packed {
        logic found;
        idx_t idx;
        ent_t ent;
    } scan_res_t;

    function automatic idx_t to_idx(logic [SLOT_W-1:0] s);
        logic [IW+SLOT_W-1:0] w;
        w = {{IW{1'b0}}, s};
        return w[IW-1:0];
    endfunction

    function automatic logic [SLOT_W-1:0] to_slot(idx_t i);
        logic [IW+SLOT_W-1:0] w;
        w = {{SLOT_W{1'b0}}, i};
        return w[SLOT_W-1:0];
    endfunction

    function automatic prio_t to_prio(logic [PRIO_IN_W-1:0] p);
        logic [PRIORITY_BITS+PRIO_IN_W-1:0] w;
        w = {{PRIORITY_BITS{1'b0}}, p};
        return w[PRIORITY_BITS-1:0];
    endfunction

    function automatic cnt_t cnt_inc(cnt_t c);
        return (c == {CNT_W{1'b1}}) ? c : c + 1'b1;
    endfunction

endpackage

// ===== rtl/priority_round_robin_task_picker.sv =====
// Priority round robin task picker: slot table in a memory, sequenced scans
// over it. A register, a plain deregister or an unused mode goes from dispatch
// straight to done; a flag update or a wake also reads its slot entry first.
// A deregister of the current task reads its entry and then takes one pass over
// the table. A schedule item takes up to two passes, one to rotate past a task
// over its budget and one to pick the next task; each pass reads the slot
// memory one entry per cycle through its single read port. One item is worked
// on at a time; a finished result sits in the output register while the next
// item is taken.
module priority_round_robin_task_picker
    import tpk_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_stall,
    input  in_t                 req,
    output logic                rsp_valid,
    input  logic                rsp_stall,
    output out_t                rsp,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [BUDGET_W-1:0] cfg_data
);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_DISP = 6'b000010,
        S_RD   = 6'b000100,
        S_NEXT = 6'b001000,
        S_MAIN = 6'b010000,
        S_DONE = 6'b100000
    } state_t;

    state_t                 state_reg, state_next;
    in_t                    item_reg, item_next;
    idx_t                   cur_reg, cur_next;
    logic                   present_reg, present_next;
    logic [NUM_SLOTS-1:0]   valid_reg, valid_next;
    logic [CW-1:0]          cnt_reg, cnt_next;
    prio_t                  curprio_reg, curprio_next;
    out_t                   res_reg, res_next;
    out_t                   out_reg, out_next;
    logic                   out_valid_reg, out_valid_next;
    logic [BUDGET_W-1:0]    budget_reg;

    logic                   we;
    idx_t                   waddr, raddr;
    ent_t                   wdata, rd;
    scan_ctl_t              sctl;
    scan_res_t              sres;
    logic                   scan_start;
    logic [CW-1:0]          cnt_m1;
    idx_t                   scan_idx;
    logic [NUM_SLOTS-1:0]   rdy_vec;
    idx_t                   si;
    logic                   in_range, sok, is_cur, scan_end;

    tpk_ram #(
        .WIDTH($bits(ent_t)),
        .DEPTH(NUM_SLOTS)
    ) u_ram (
        .clk  (clk),
        .we   (we),
        .waddr(waddr),
        .wdata(wdata),
        .raddr(raddr),
        .rdata(rd)
    );

    tpk_scan u_scan (
        .clk  (clk),
        .rst_n(rst_n),
        .ctl  (sctl),
        .ent  (rd),
        .res  (sres)
    );

    always_comb
    begin
        for (int i = 0; i < NUM_SLOTS; i++)
        begin
            rdy_vec[i] = (i < READY_W) ? item_reg.ready_mask[i % READY_W] : 1'b0;
        end
    end

    assign cnt_m1   = cnt_reg - 1'b1;
    assign scan_idx = cnt_m1[IW-1:0];
    assign scan_end = (cnt_reg == CW'(SCAN_LAST));
    assign si       = to_idx(item_reg.slot);
    assign in_range = (int'(item_reg.slot) < NUM_SLOTS);
    assign sok      = in_range && valid_reg[si];
    assign is_cur   = present_reg && (cur_reg == si);

    assign sctl.start      = scan_start;
    assign sctl.ev         = ((state_reg == S_NEXT) || (state_reg == S_MAIN)) &&
                             (cnt_reg != '0) && !scan_end;
    assign sctl.kind_next  = (state_reg == S_NEXT);
    assign sctl.present    = present_reg;
    assign sctl.idx        = scan_idx;
    assign sctl.cur        = cur_reg;
    assign sctl.curprio    = curprio_reg;
    assign sctl.slot_valid = valid_reg[scan_idx];
    assign sctl.rdy        = rdy_vec[scan_idx];

    always_comb
    begin
        state_next     = state_reg;
        item_next      = item_reg;
        cur_next       = cur_reg;
        present_next   = present_reg;
        valid_next     = valid_reg;
        cnt_next       = cnt_reg;
        curprio_next   = curprio_reg;
        res_next       = res_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && rsp_stall;
        we             = 1'b0;
        waddr          = si;
        wdata          = rd;
        raddr          = cnt_reg[IW-1:0];
        scan_start     = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    item_next  = req;
                    state_next = S_DISP;
                end
            end
            S_DISP:
            begin
                state_next = S_DONE;
                case (item_reg.mode)
                    MODE_REG:
                    begin
                        if (in_range)
                        begin
                            we             = 1'b1;
                            wdata.prio     = to_prio(item_reg.task_priority);
                            wdata.sw       = item_reg.can_switch;
                            wdata.blk      = item_reg.may_block;
                            wdata.uns      = item_reg.not_stable;
                            wdata.cnt      = '0;
                            valid_next[si] = 1'b1;
                        end
                        res_next = '{OC_TABLE, item_reg.slot, 1'b0, 1'b0};
                    end
                    MODE_UPD:
                    begin
                        res_next = '{OC_TABLE, item_reg.slot, 1'b0, 1'b0};
                        if (sok)
                        begin
                            raddr      = si;
                            state_next = S_RD;
                        end
                    end
                    MODE_DEREG:
                    begin
                        if (sok && is_cur)
                        begin
                            raddr      = si;
                            state_next = S_RD;
                        end
                        else
                        begin
                            if (sok)
                            begin
                                valid_next[si] = 1'b0;
                            end
                            res_next = present_reg ?
                                '{OC_TABLE, to_slot(cur_reg), 1'b0, 1'b0} :
                                '{OC_NONE, '0, 1'b0, 1'b0};
                        end
                    end
                    MODE_WAKE:
                    begin
                        res_next = '{OC_WAIT, '0, 1'b0, 1'b0};
                        if (sok)
                        begin
                            raddr      = si;
                            state_next = S_RD;
                        end
                    end
                    MODE_SCHED:
                    begin
                        if (present_reg)
                        begin
                            raddr      = cur_reg;
                            state_next = S_RD;
                        end
                        else if (sok)
                        begin
                            cur_next     = si;
                            present_next = 1'b1;
                            raddr        = si;
                            state_next   = S_RD;
                        end
                        else if (|valid_reg)
                        begin
                            cnt_next   = '0;
                            scan_start = 1'b1;
                            state_next = S_MAIN;
                        end
                        else
                        begin
                            res_next = '{OC_NONE, '0, 1'b0, 1'b0};
                        end
                    end
                    default:
                    begin
                        res_next = '{OC_TABLE, '0, 1'b0, 1'b0};
                    end
                endcase
            end
            S_RD:
            begin
                case (item_reg.mode)
                    MODE_UPD:
                    begin
                        we         = 1'b1;
                        wdata.sw   = item_reg.can_switch;
                        wdata.blk  = item_reg.may_block;
                        wdata.uns  = item_reg.not_stable;
                        state_next = S_DONE;
                    end
                    MODE_WAKE:
                    begin
                        we           = 1'b1;
                        wdata.cnt    = is_cur ? cnt_inc(rd.cnt) : '0;
                        cur_next     = si;
                        present_next = 1'b1;
                        res_next     = '{OC_SELECT, to_slot(si), 1'b1, 1'b0};
                        state_next   = S_DONE;
                    end
                    MODE_DEREG:
                    begin
                        curprio_next = rd.prio;
                        cnt_next     = '0;
                        scan_start   = 1'b1;
                        state_next   = S_NEXT;
                    end
                    default:
                    begin
                        curprio_next = rd.prio;
                        cnt_next     = '0;
                        if (!rd.sw)
                        begin
                            res_next   = '{OC_SELECT, to_slot(cur_reg), rd.blk, rd.blk};
                            state_next = S_DONE;
                        end
                        else if (rd.cnt > {1'b0, budget_reg})
                        begin
                            // over budget: clear the counter and rotate in the level
                            we         = 1'b1;
                            waddr      = cur_reg;
                            wdata.cnt  = '0;
                            scan_start = 1'b1;
                            state_next = S_NEXT;
                        end
                        else
                        begin
                            scan_start = 1'b1;
                            state_next = S_MAIN;
                        end
                    end
                endcase
            end
            S_NEXT:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (scan_end)
                begin
                    if (item_reg.mode == MODE_DEREG)
                    begin
                        valid_next[si] = 1'b0;
                        if (sres.found)
                        begin
                            cur_next = sres.idx;
                            res_next = '{OC_TABLE, to_slot(sres.idx), 1'b0, 1'b0};
                        end
                        else
                        begin
                            present_next = 1'b0;
                            res_next     = '{OC_NONE, '0, 1'b0, 1'b0};
                        end
                        state_next = S_DONE;
                    end
                    else
                    begin
                        if (sres.found)
                        begin
                            cur_next = sres.idx;
                        end
                        cnt_next   = '0;
                        scan_start = 1'b1;
                        state_next = S_MAIN;
                    end
                end
            end
            S_MAIN:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (scan_end)
                begin
                    if (!sres.found || sres.ent.uns)
                    begin
                        res_next = '{OC_WAIT, '0, 1'b0, 1'b0};
                    end
                    else
                    begin
                        we           = 1'b1;
                        waddr        = sres.idx;
                        wdata        = sres.ent;
                        wdata.cnt    = (present_reg && cur_reg == sres.idx) ?
                                       cnt_inc(sres.ent.cnt) : '0;
                        cur_next     = sres.idx;
                        present_next = 1'b1;
                        res_next     = '{OC_SELECT, to_slot(sres.idx), sres.ent.blk, 1'b0};
                    end
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || !rsp_stall)
                begin
                    out_next       = res_reg;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cur_reg       <= '0;
            present_reg   <= 1'b0;
            valid_reg     <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
            budget_reg    <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            cur_reg       <= cur_next;
            present_reg   <= present_next;
            valid_reg     <= valid_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                budget_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg    <= item_next;
        curprio_reg <= curprio_next;
        res_reg     <= res_next;
        out_reg     <= out_next;
    end

    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;
    assign cfg_ready = 1'b1;

    // the current task always names a live slot
    a_cur_valid: assert property (@(posedge clk) disable iff (!rst_n)
        present_reg |-> valid_reg[cur_reg])
        else $error("current slot is not valid");

    // a selection leaves a current task behind
    a_sel_present: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && state_next == S_IDLE && res_reg.outcome == OC_SELECT)
        |=> present_reg)
        else $error("task selected but no current task");

    // waiting on the current task is always a status-change selection
    a_wait_flag: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.wait_on_current |-> rsp.by_status_change &&
        rsp.outcome == OC_SELECT)
        else $error("wait on current without status change");

    // the pass counter never runs beyond SCAN_LAST
    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_NEXT || state_reg == S_MAIN) |-> cnt_reg <= CW'(SCAN_LAST))
        else $error("scan counter overrun");

    // a new item is only taken when no work is in flight
    a_accept_idle: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall |=> state_reg == S_DISP)
        else $error("item taken outside idle");

endmodule

// ===== rtl/tpk_ram.sv =====
// generic single write, single registered read memory
module tpk_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/tpk_scan.sv =====
// scan unit: ranks the streamed table entries and keeps the best candidate
module tpk_scan
    import tpk_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  scan_ctl_t ctl,
    input  ent_t      ent,
    output scan_res_t res
);

    logic                     found_reg;
    idx_t                     best_idx_reg;
    ent_t                     best_ent_reg;
    logic [PRIORITY_BITS+IW-1:0] best_key_reg;

    logic [IW:0]                 ring_gap;
    logic                        same_level;
    logic                        cand;
    logic [PRIORITY_BITS+IW-1:0] key;

    always_comb
    begin
        ring_gap = {1'b0, ctl.idx} - {1'b0, ctl.cur};
        if (ctl.idx < ctl.cur)
        begin
            ring_gap = ring_gap + (IW + 1)'(NUM_SLOTS);
        end
        same_level = ctl.present && (ent.prio == ctl.curprio);
        if (ctl.kind_next)
        begin
            // next slot of the current level in cyclic order
            cand = ctl.slot_valid && same_level && (ctl.idx != ctl.cur);
            key  = {ent.prio, ring_gap[IW-1:0]};
        end
        else
        begin
            // stop on unstable, runnable, or blocked with status change
            cand = ctl.slot_valid && (ent.uns || !ent.blk || ctl.rdy);
            key  = {ent.prio, same_level ? ring_gap[IW-1:0] : ctl.idx};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg <= 1'b0;
        end
        else if (ctl.start)
        begin
            found_reg <= 1'b0;
        end
        else if (ctl.ev && cand && (!found_reg || key < best_key_reg))
        begin
            found_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!ctl.start && ctl.ev && cand && (!found_reg || key < best_key_reg))
        begin
            best_key_reg <= key;
            best_idx_reg <= ctl.idx;
            best_ent_reg <= ent;
        end
    end

    assign res.found = found_reg;
    assign res.idx   = best_idx_reg;
    assign res.ent   = best_ent_reg;

endmodule

// ===== dv/priority_round_robin_task_picker_test.sv =====
// self-checking testbench for the priority round robin task picker
`timescale 1ns / 100ps

module priority_round_robin_task_picker_test;
    import tpk_pkg::*;

    localparam logic [2:0] MODE_SPARE_FIRST = 3'd5;
    localparam logic [2:0] MODE_SPARE_MID   = 3'd6;
    localparam logic [2:0] MODE_SPARE_LAST  = 3'd7;
    localparam int         WATCHDOG_LIMIT   = 20000;
    localparam int         DRAIN_CYCLES     = 2 * NUM_SLOTS + 40;
    localparam int         HOLD_CYCLES      = 400;
    localparam cnt_t       CNT_MAX          = {CNT_W{1'b1}};

    logic                clk;
    logic                rst_n;
    logic                req_valid;
    logic                req_stall;
    in_t                 req;
    logic                rsp_valid;
    logic                rsp_stall;
    out_t                rsp;
    logic                cfg_valid;
    logic                cfg_ready;
    logic [BUDGET_W-1:0] cfg_data;

    priority_round_robin_task_picker uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // shadow of the task table
    logic                tbl_valid [NUM_SLOTS];
    prio_t               tbl_prio  [NUM_SLOTS];
    logic                tbl_sw    [NUM_SLOTS];
    logic                tbl_blk   [NUM_SLOTS];
    logic                tbl_uns   [NUM_SLOTS];
    cnt_t                tbl_cnt   [NUM_SLOTS];
    int                  cur_task;
    logic                cur_live;
    logic [BUDGET_W-1:0] budget;

    in_t  pending_items[$];
    out_t expected_picks[$];

    int   send_idle_pct;
    int   recv_idle_pct;
    logic hold_request;
    int   mismatches;
    int   quiet_cycles;
    logic timed_out;

    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    function automatic int next_in_level(int c);
        int k;
        int idx;
        for (k = 1; k < NUM_SLOTS; k++)
        begin
            idx = (c + k) % NUM_SLOTS;
            if (tbl_valid[idx] && tbl_prio[idx] == tbl_prio[c])
                return idx;
        end
        return c;
    endfunction

    function automatic void take_task(int n);
        if (cur_live && cur_task == n)
        begin
            if (tbl_cnt[n] != CNT_MAX)
                tbl_cnt[n] = tbl_cnt[n] + 1'b1;
        end
        else
            tbl_cnt[n] = '0;
        cur_task = n;
        cur_live = 1'b1;
    endfunction

    function automatic out_t pick_task(in_t it);
        out_t  o;
        int    s;
        logic  sok;
        logic  any;
        logic  have_level;
        logic  found;
        prio_t level;
        prio_t best;
        int    start;
        int    idx;
        int    n;
        int    i;
        int    k;
        int    nx;
        o   = '0;
        s   = int'(it.slot);
        sok = tbl_valid[s];
        case (it.mode)
            MODE_REG:
            begin
                tbl_valid[s] = 1'b1;
                tbl_prio[s]  = to_prio(it.task_priority);
                tbl_sw[s]    = it.can_switch;
                tbl_blk[s]   = it.may_block;
                tbl_uns[s]   = it.not_stable;
                tbl_cnt[s]   = '0;
                o.outcome     = OC_TABLE;
                o.chosen_slot = it.slot;
                return o;
            end
            MODE_UPD:
            begin
                if (sok)
                begin
                    tbl_sw[s]  = it.can_switch;
                    tbl_blk[s] = it.may_block;
                    tbl_uns[s] = it.not_stable;
                end
                o.outcome     = OC_TABLE;
                o.chosen_slot = it.slot;
                return o;
            end
            MODE_DEREG:
            begin
                if (sok)
                begin
                    if (cur_live && cur_task == s)
                    begin
                        nx = next_in_level(s);
                        if (nx == s)
                            cur_live = 1'b0;
                        else
                            cur_task = nx;
                    end
                    tbl_valid[s] = 1'b0;
                end
                if (cur_live)
                begin
                    o.outcome     = OC_TABLE;
                    o.chosen_slot = SLOT_W'(cur_task);
                end
                else
                    o.outcome = OC_NONE;
                return o;
            end
            MODE_WAKE:
            begin
                if (!sok)
                begin
                    o.outcome = OC_WAIT;
                    return o;
                end
                take_task(s);
                o.outcome          = OC_SELECT;
                o.chosen_slot      = SLOT_W'(s);
                o.by_status_change = 1'b1;
                return o;
            end
            MODE_SCHED:
            begin
            end
            default:
            begin
                o.outcome = OC_TABLE;
                return o;
            end
        endcase

        if (!cur_live && sok)
        begin
            cur_task = s;
            cur_live = 1'b1;
        end
        if (cur_live && !tbl_sw[cur_task])
        begin
            o.outcome          = OC_SELECT;
            o.chosen_slot      = SLOT_W'(cur_task);
            o.by_status_change = tbl_blk[cur_task];
            o.wait_on_current  = tbl_blk[cur_task];
            return o;
        end
        if (cur_live && tbl_cnt[cur_task] > budget)
        begin
            tbl_cnt[cur_task] = '0;
            cur_task = next_in_level(cur_task);
        end
        any = 1'b0;
        for (i = 0; i < NUM_SLOTS; i++)
            any |= tbl_valid[i];
        if (!any)
        begin
            o.outcome = OC_NONE;
            return o;
        end
        have_level = 1'b0;
        level      = '0;
        for (n = 0; n < NUM_SLOTS; n++)
        begin
            found = 1'b0;
            best  = '0;
            for (i = 0; i < NUM_SLOTS; i++)
            begin
                if (tbl_valid[i] && !(have_level && tbl_prio[i] <= level)
                    && (!found || tbl_prio[i] < best))
                begin
                    best  = tbl_prio[i];
                    found = 1'b1;
                end
            end
            if (!found)
                break;
            level      = best;
            have_level = 1'b1;
            start      = 0;
            if (cur_live && tbl_prio[cur_task] == level)
                start = cur_task;
            else
                for (i = NUM_SLOTS - 1; i >= 0; i--)
                    if (tbl_valid[i] && tbl_prio[i] == level)
                        start = i;
            for (k = 0; k < NUM_SLOTS; k++)
            begin
                idx = (start + k) % NUM_SLOTS;
                if (!tbl_valid[idx] || tbl_prio[idx] != level)
                    continue;
                if (tbl_uns[idx])
                begin
                    o.outcome = OC_WAIT;
                    return o;
                end
                if (!tbl_blk[idx] || it.ready_mask[idx])
                begin
                    o.by_status_change = tbl_blk[idx];
                    take_task(idx);
                    o.outcome     = OC_SELECT;
                    o.chosen_slot = SLOT_W'(idx);
                    return o;
                end
            end
        end
        o.outcome = OC_WAIT;
        return o;
    endfunction

    // driver: a held item stays put until it is taken
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid <= 1'b0;
            req       <= '0;
        end
        else if (!req_valid || !req_stall)
        begin
            if (req_valid)
                expected_picks.push_back(pick_task(req));
            if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct)
            begin
                req       <= pending_items.pop_front();
                req_valid <= 1'b1;
            end
            else
                req_valid <= 1'b0;
        end
    end

    // receiver: random stalls plus one long hold-off on request
    int   hold_left;
    logic hold_done;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_stall <= 1'b1;
            hold_left <= 0;
            hold_done <= 1'b0;
        end
        else if (hold_request && !hold_done)
        begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
            rsp_stall <= 1'b1;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            rsp_stall <= 1'b1;
        end
        else
            rsp_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    // monitor
    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (expected_picks.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected item: outcome %0d slot %0d", rsp.outcome,
                             rsp.chosen_slot);
            end
            else
            begin
                out_t e;
                e = expected_picks.pop_front();
                if (rsp !== e)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"mismatch: expected oc %0d slot %0d chg %0b wt %0b,",
                                  " got oc %0d slot %0d chg %0b wt %0b"},
                                 e.outcome, e.chosen_slot, e.by_status_change,
                                 e.wait_on_current, rsp.outcome, rsp.chosen_slot,
                                 rsp.by_status_change, rsp.wait_on_current);
                end
            end
        end
    end

    // watchdog on cycles with no handshake of any kind
    always @(posedge clk)
    begin
        if (!rst_n || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)
            || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT && !timed_out)
        begin
            timed_out = 1'b1;
            $display("** priority_round_robin_task_picker: FAILED **");
            $finish;
        end
    end

    task automatic add_item(logic [2:0] m, int s, int p, logic sw, logic blk, logic uns,
                            logic [READY_W-1:0] rdy);
        in_t it;
        it.mode          = m;
        it.slot          = SLOT_W'(s);
        it.task_priority = PRIO_IN_W'(p);
        it.can_switch    = sw;
        it.may_block     = blk;
        it.not_stable    = uns;
        it.ready_mask    = rdy;
        pending_items.push_back(it);
    endtask

    task automatic add_random_items(int count);
        in_t it;
        int  r;
        repeat (count)
        begin
            r = $urandom_range(99);
            it.mode = (r < 38) ? MODE_SCHED : (r < 58) ? MODE_REG : (r < 70) ? MODE_UPD :
                      (r < 82) ? MODE_DEREG : (r < 96) ? MODE_WAKE :
                      3'($urandom_range(MODE_SPARE_LAST, MODE_SPARE_FIRST));
            it.slot          = SLOT_W'($urandom_range(NUM_SLOTS - 1));
            it.task_priority = ($urandom_range(9) == 0) ? PRIO_IN_W'($urandom_range(255))
                                                        : PRIO_IN_W'($urandom_range(3));
            it.can_switch    = ($urandom_range(9) < 8);
            it.may_block     = ($urandom_range(9) < 4);
            it.not_stable    = ($urandom_range(19) == 0);
            it.ready_mask    = READY_W'($urandom_range(16'hFFFF));
            pending_items.push_back(it);
        end
    endtask

    task automatic wait_idle();
        while (pending_items.size() > 0 || req_valid || expected_picks.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_budget(logic [BUDGET_W-1:0] v);
        wait_idle();
        cfg_data  <= v;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        budget = v;
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        int i;
        for (i = 0; i < NUM_SLOTS; i++)
        begin
            tbl_valid[i] = 1'b0;
            tbl_prio[i]  = '0;
            tbl_sw[i]    = 1'b0;
            tbl_blk[i]   = 1'b0;
            tbl_uns[i]   = 1'b0;
            tbl_cnt[i]   = '0;
        end
        cur_task      = 0;
        cur_live      = 1'b0;
        budget        = '0;
        mismatches    = 0;
        quiet_cycles  = 0;
        timed_out     = 1'b0;
        hold_request  = 1'b0;
        send_idle_pct = 28;
        recv_idle_pct = 86;
        cfg_valid     = 1'b0;
        cfg_data      = '0;
        rst_n         = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_budget(16'd0);
        // empty table, unknown slots, spare modes
        add_item(MODE_SCHED, 3, 0, 1, 0, 0, 16'h0000);
        add_item(MODE_WAKE, 15, 0, 0, 0, 0, 16'hFFFF);
        add_item(MODE_UPD, 7, 0, 1, 1, 1, 16'h0000);
        add_item(MODE_DEREG, 7, 0, 0, 0, 0, 16'h0000);
        add_item(MODE_SPARE_FIRST, 1, 255, 1, 1, 1, 16'hFFFF);
        add_item(MODE_SPARE_MID, 2, 0, 0, 0, 0, 16'h0000);
        add_item(MODE_SPARE_LAST, 15, 255, 1, 1, 1, 16'h5555);
        // two tasks at one level, a blocked one and an unstable one
        add_item(MODE_REG, 0, 0, 1, 0, 0, 16'h0000);
        add_item(MODE_REG, 15, 0, 1, 0, 0, 16'h0000);
        add_item(MODE_REG, 5, 255, 1, 1, 0, 16'h0000);
        add_item(MODE_SCHED, 0, 0, 0, 0, 0, 16'h0000);
        add_item(MODE_SCHED, 0, 0, 0, 0, 0, 16'h0000);
        add_item(MODE_SCHED, 0, 0, 0, 0, 0, 16'h0000);
        add_item(MODE_DEREG, 0, 0, 0, 0, 0, 16'h0000);
        add_item(MODE_DEREG, 15, 0, 0, 0, 0, 16'h0000);
        add_item(MODE_SCHED, 5, 0, 0, 0, 0, 16'h0000);
        add_item(MODE_SCHED, 5, 0, 0, 0, 0, 16'h0020);
        add_item(MODE_UPD, 5, 0, 0, 1, 0, 16'h0000);
        add_item(MODE_SCHED, 5, 0, 0, 0, 0, 16'h0000);
        add_item(MODE_WAKE, 5, 0, 0, 0, 0, 16'h0000);
        add_item(MODE_REG, 9, 1, 1, 0, 1, 16'h0000);
        add_item(MODE_UPD, 5, 0, 1, 0, 0, 16'h0000);
        add_item(MODE_DEREG, 5, 0, 0, 0, 0, 16'h0000);
        add_item(MODE_SCHED, 9, 0, 0, 0, 0, 16'hAAAA);
        add_item(MODE_DEREG, 9, 0, 0, 0, 0, 16'h0000);

        write_budget(16'hFFFF);
        add_random_items(500);
        write_budget(16'd2);
        send_idle_pct = 86;
        recv_idle_pct = 28;
        add_random_items(500);
        write_budget(16'd1);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        add_random_items(500);
        hold_request = 1'b1;

        wait_idle();
        if (mismatches == 0)
            $display("** priority_round_robin_task_picker: PASSED **");
        else
            $display("** priority_round_robin_task_picker: FAILED **");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/tpk_pkg.sv
rtl/tpk_ram.sv
rtl/tpk_scan.sv
rtl/priority_round_robin_task_picker.sv
dv/priority_round_robin_task_picker_test.sv
